// ===== hw/rtl/rqt_pkg.sv =====
`default_nettype none

package rqt_pkg;

  localparam int unsigned SLOT_W        = 4;
  localparam int unsigned SLOTS         = 1 << SLOT_W;
  localparam int unsigned MAX_OUT       = 16;
  localparam int unsigned CNT_W         = $clog2(MAX_OUT + 1);
  localparam int unsigned ID_W          = 16;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned CNT2_W        = 2;
  localparam int unsigned TICK_W        = 32;
  localparam int unsigned TIMEOUT_W     = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10;
  localparam logic [CNT2_W-1:0]    REPLICAS      = 2'd3;
  localparam logic [CNT2_W-1:0]    QUORUM        = 2'd2;

  typedef enum logic [1:0] {
    REQ_OPEN  = 2'd0,
    REQ_REPLY = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    OC_SUCCESS = 2'd0,
    OC_FAILURE = 2'd1,
    OC_TIMEOUT = 2'd2,
    OC_REJECT  = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [OP_W-1:0]   op;
    logic [CNT2_W-1:0] replies;
    logic [CNT2_W-1:0] successes;
    logic [TICK_W-1:0] start;
  } slot_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/replica_quorum_tracker_unit.sv =====
`default_nettype none

// 2-of-3 quorum tracker for replicated requests. Open and reply transactions
// hit the slot given by the low bits of trans_id: a synchronous read of the
// slot memory, then the update and write-back, held while a result cannot be
// taken. A tick transaction increments the time base and scans all slots in
// index order, one slot per cycle through the same read port unless a timeout
// result must wait for the output register. Timed-out entries are reported
// with outcome 2, at most 16 per tick, the final one flagged by out_last_o.
// Results wait in an output register, so results already produced do not
// block the input side. The user must write timeout_ticks through cfg_we_i /
// cfg_wdata_i only while idle; the block itself does not enforce this.
module replica_quorum_tracker_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,

  input  wire logic                         cfg_we_i,
  input  wire logic [rqt_pkg::TIMEOUT_W-1:0] cfg_wdata_i,

  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [1:0]                   in_req_type_i,
  input  wire logic [rqt_pkg::ID_W-1:0]     in_trans_id_i,
  input  wire logic [rqt_pkg::OP_W-1:0]     in_op_kind_i,
  input  wire logic                         in_reply_ok_i,

  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic [rqt_pkg::ID_W-1:0]     out_done_id_o,
  output      logic [rqt_pkg::OP_W-1:0]     out_done_op_o,
  output      logic [1:0]                   out_outcome_o,
  output      logic                         out_last_o
);

  localparam int unsigned SW = rqt_pkg::SLOT_W;

  rqt_pkg::state_e                  state_q, state_d;
  logic [rqt_pkg::TIMEOUT_W-1:0]    timeout_q;
  logic [rqt_pkg::TICK_W-1:0]       now_q, now_d;
  logic [rqt_pkg::SLOTS-1:0]        valid_q, valid_d;
  logic [SW-1:0]                    idx_q, idx_d;
  logic [rqt_pkg::CNT_W-1:0]        cnt_q, cnt_d;

  logic [1:0]                       item_type_q;
  logic [rqt_pkg::ID_W-1:0]         item_id_q;
  logic [rqt_pkg::OP_W-1:0]         item_op_q;
  logic                             item_ok_q;
  logic [SW-1:0]                    item_slot;

  logic                             pend_valid_q, pend_valid_d;
  logic [rqt_pkg::ID_W-1:0]         pend_id_q, pend_id_d;
  logic [rqt_pkg::OP_W-1:0]         pend_op_q, pend_op_d;

  logic                             out_valid_q, out_valid_d;
  logic [rqt_pkg::ID_W-1:0]         out_id_q, out_id_d;
  logic [rqt_pkg::OP_W-1:0]         out_op_q, out_op_d;
  logic [1:0]                       out_oc_q, out_oc_d;
  logic                             out_last_q, out_last_d;
  logic                             out_load;
  logic                             out_free;

  rqt_pkg::slot_entry_t             slot_mem [rqt_pkg::SLOTS];
  rqt_pkg::slot_entry_t             rd_data_q;
  rqt_pkg::slot_entry_t             wr_data;
  logic [SW-1:0]                    rd_addr;
  logic                             mem_we;

  logic                             in_accept;
  logic                             slot_busy;
  logic                             reply_match;
  logic [rqt_pkg::CNT2_W-1:0]       new_replies;
  logic [rqt_pkg::CNT2_W-1:0]       new_succ;
  logic [rqt_pkg::CNT2_W-1:0]       new_fails;
  logic                             resolved;
  logic [1:0]                       reply_oc;
  logic                             rmw_emit;
  logic                             rmw_go;
  logic [rqt_pkg::TICK_W-1:0]       age;
  logic                             scan_hit;
  logic                             scan_go;
  logic                             flush_go;

  assign in_stall_o = (state_q != rqt_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign item_slot  = item_id_q[SW-1:0];

  // slot update
  assign slot_busy   = valid_q[item_slot];
  assign reply_match = slot_busy && (rd_data_q.id == item_id_q);
  assign new_replies = rd_data_q.replies + 2'd1;
  assign new_succ    = rd_data_q.successes + {1'b0, item_ok_q};
  assign new_fails   = new_replies - new_succ;

  always_comb begin
    resolved = 1'b0;
    reply_oc = rqt_pkg::OC_FAILURE;
    if (new_replies >= rqt_pkg::REPLICAS) begin
      resolved = 1'b1;
      reply_oc = (new_succ >= rqt_pkg::QUORUM) ? rqt_pkg::OC_SUCCESS : rqt_pkg::OC_FAILURE;
    end else if (new_succ >= rqt_pkg::QUORUM) begin
      resolved = 1'b1;
      reply_oc = rqt_pkg::OC_SUCCESS;
    end else if (new_fails >= rqt_pkg::QUORUM) begin
      resolved = 1'b1;
      reply_oc = rqt_pkg::OC_FAILURE;
    end
  end

  always_comb begin
    case (item_type_q)
      rqt_pkg::REQ_OPEN:  rmw_emit = slot_busy;
      rqt_pkg::REQ_REPLY: rmw_emit = reply_match && resolved;
      default:            rmw_emit = 1'b0;
    endcase
  end

  assign rmw_go = !rmw_emit || out_free;

  // timeout scan
  assign age      = now_q - rd_data_q.start;
  assign scan_hit = valid_q[idx_q] && (age > {16'd0, timeout_q})
                    && (cnt_q < rqt_pkg::CNT_W'(rqt_pkg::MAX_OUT));
  assign scan_go  = !(scan_hit && pend_valid_q) || out_free;
  assign flush_go = !pend_valid_q || out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rqt_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_req_type_i)
            rqt_pkg::REQ_OPEN, rqt_pkg::REQ_REPLY: state_d = rqt_pkg::ST_RMW;
            rqt_pkg::REQ_TICK:                     state_d = rqt_pkg::ST_SCAN;
            default:                               state_d = rqt_pkg::ST_IDLE;
          endcase
        end
      end
      rqt_pkg::ST_RMW: begin
        if (rmw_go) state_d = rqt_pkg::ST_IDLE;
      end
      rqt_pkg::ST_SCAN: begin
        if (scan_go && (idx_q == SW'(rqt_pkg::SLOTS - 1))) state_d = rqt_pkg::ST_FLUSH;
      end
      rqt_pkg::ST_FLUSH: begin
        if (flush_go) state_d = rqt_pkg::ST_IDLE;
      end
      default: state_d = rqt_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    now_d        = now_q;
    valid_d      = valid_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    pend_op_d    = pend_op_q;
    out_load     = 1'b0;
    out_id_d     = out_id_q;
    out_op_d     = out_op_q;
    out_oc_d     = out_oc_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    wr_data      = rd_data_q;
    rd_addr      = item_slot;
    case (state_q)
      rqt_pkg::ST_IDLE: begin
        rd_addr = in_trans_id_i[SW-1:0];
        if (in_accept && (in_req_type_i == rqt_pkg::REQ_TICK)) begin
          now_d        = now_q + 32'd1;
          idx_d        = '0;
          cnt_d        = '0;
          pend_valid_d = 1'b0;
          rd_addr      = '0;
        end
      end
      rqt_pkg::ST_RMW: begin
        if (rmw_go) begin
          if (item_type_q == rqt_pkg::REQ_OPEN) begin
            if (slot_busy) begin
              out_load   = 1'b1;
              out_id_d   = item_id_q;
              out_op_d   = item_op_q;
              out_oc_d   = rqt_pkg::OC_REJECT;
              out_last_d = 1'b1;
            end else begin
              mem_we             = 1'b1;
              wr_data.id         = item_id_q;
              wr_data.op         = item_op_q;
              wr_data.replies    = '0;
              wr_data.successes  = '0;
              wr_data.start      = now_q;
              valid_d[item_slot] = 1'b1;
            end
          end else if (reply_match) begin
            mem_we            = 1'b1;
            wr_data.replies   = new_replies;
            wr_data.successes = new_succ;
            if (resolved) begin
              valid_d[item_slot] = 1'b0;
              out_load           = 1'b1;
              out_id_d           = rd_data_q.id;
              out_op_d           = rd_data_q.op;
              out_oc_d           = reply_oc;
              out_last_d         = 1'b1;
            end
          end
        end
      end
      rqt_pkg::ST_SCAN: begin
        if (scan_go) begin
          if (scan_hit) begin
            if (pend_valid_q) begin
              out_load   = 1'b1;
              out_id_d   = pend_id_q;
              out_op_d   = pend_op_q;
              out_oc_d   = rqt_pkg::OC_TIMEOUT;
              out_last_d = 1'b0;
            end
            pend_valid_d   = 1'b1;
            pend_id_d      = rd_data_q.id;
            pend_op_d      = rd_data_q.op;
            valid_d[idx_q] = 1'b0;
            cnt_d          = cnt_q + 1'b1;
          end
          idx_d = idx_q + 1'b1;
        end
        rd_addr = idx_d;
      end
      rqt_pkg::ST_FLUSH: begin
        if (pend_valid_q && out_free) begin
          out_load     = 1'b1;
          out_id_d     = pend_id_q;
          out_op_d     = pend_op_q;
          out_oc_d     = rqt_pkg::OC_TIMEOUT;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rqt_pkg::ST_IDLE;
      timeout_q    <= rqt_pkg::TIMEOUT_RESET;
      now_q        <= '0;
      valid_q      <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      now_q        <= now_d;
      valid_q      <= valid_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_type_q <= in_req_type_i;
      item_id_q   <= in_trans_id_i;
      item_op_q   <= in_op_kind_i;
      item_ok_q   <= in_reply_ok_i;
    end
    pend_id_q <= pend_id_d;
    pend_op_q <= pend_op_d;
    if (out_load) begin
      out_id_q   <= out_id_d;
      out_op_q   <= out_op_d;
      out_oc_q   <= out_oc_d;
      out_last_q <= out_last_d;
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[item_slot] <= wr_data;
    end
    rd_data_q <= slot_mem[rd_addr];
  end

  assign out_valid_o   = out_valid_q;
  assign out_done_id_o = out_id_q;
  assign out_done_op_o = out_op_q;
  assign out_outcome_o = out_oc_q;
  assign out_last_o    = out_last_q;

endmodule

`default_nettype wire

// ===== tb/sv/rqt_outcome_checker.sv =====
`timescale 1ns / 1ps

module rqt_outcome_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rqt_pkg::TIMEOUT_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [1:0]                    in_req_type_i,
  input  logic [rqt_pkg::ID_W-1:0]      in_trans_id_i,
  input  logic [rqt_pkg::OP_W-1:0]      in_op_kind_i,
  input  logic                          in_reply_ok_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [rqt_pkg::ID_W-1:0]      out_done_id_o,
  input  logic [rqt_pkg::OP_W-1:0]      out_done_op_o,
  input  logic [1:0]                    out_outcome_o,
  input  logic                          out_last_o,
  output int unsigned                   errors_o,
  output int unsigned                   pending_o
);

  typedef struct packed {
    logic [rqt_pkg::ID_W-1:0] id;
    logic [rqt_pkg::OP_W-1:0] op;
    rqt_pkg::outcome_e        oc;
    logic                     last;
  } done_t;

  done_t done_q[$];

  logic                          live      [rqt_pkg::SLOTS];
  logic [rqt_pkg::ID_W-1:0]      owner_id  [rqt_pkg::SLOTS];
  logic [rqt_pkg::OP_W-1:0]      owner_op  [rqt_pkg::SLOTS];
  logic [rqt_pkg::CNT2_W-1:0]    replies   [rqt_pkg::SLOTS];
  logic [rqt_pkg::CNT2_W-1:0]    successes [rqt_pkg::SLOTS];
  logic [rqt_pkg::TICK_W-1:0]    opened_at [rqt_pkg::SLOTS];
  logic [rqt_pkg::TICK_W-1:0]    now_q;
  logic [rqt_pkg::TIMEOUT_W-1:0] timeout_q;

  task automatic push_done(input logic [rqt_pkg::ID_W-1:0] id,
                           input logic [rqt_pkg::OP_W-1:0] op,
                           input rqt_pkg::outcome_e oc, input logic last);
    done_t d;
    d.id   = id;
    d.op   = op;
    d.oc   = oc;
    d.last = last;
    done_q.push_back(d);
  endtask

  task automatic track_request(input rqt_pkg::req_type_e kind,
                               input logic [rqt_pkg::ID_W-1:0] id,
                               input logic [rqt_pkg::OP_W-1:0] op, input logic ok);
    logic [rqt_pkg::SLOT_W-1:0] s;
    logic [rqt_pkg::CNT2_W-1:0] r;
    logic [rqt_pkg::CNT2_W-1:0] g;
    logic [rqt_pkg::CNT2_W-1:0] nok;
    logic                       resolved;
    rqt_pkg::outcome_e          oc;
    int                         n;
    int                         prev;
    s        = id[rqt_pkg::SLOT_W-1:0];
    resolved = 1'b0;
    oc       = rqt_pkg::OC_SUCCESS;
    n        = 0;
    prev     = -1;
    case (kind)
      rqt_pkg::REQ_OPEN: begin
        if (live[s]) begin
          push_done(id, op, rqt_pkg::OC_REJECT, 1'b1);
        end else begin
          live[s]      = 1'b1;
          owner_id[s]  = id;
          owner_op[s]  = op;
          replies[s]   = '0;
          successes[s] = '0;
          opened_at[s] = now_q;
        end
      end
      rqt_pkg::REQ_REPLY: begin
        if (live[s] && owner_id[s] == id) begin
          r            = replies[s] + 2'd1;
          g            = successes[s] + {1'b0, ok};
          nok          = r - g;
          replies[s]   = r;
          successes[s] = g;
          if (r >= rqt_pkg::REPLICAS) begin
            resolved = 1'b1;
            oc       = (g >= rqt_pkg::QUORUM) ? rqt_pkg::OC_SUCCESS : rqt_pkg::OC_FAILURE;
          end else if (g >= rqt_pkg::QUORUM) begin
            resolved = 1'b1;
            oc       = rqt_pkg::OC_SUCCESS;
          end else if (nok >= rqt_pkg::QUORUM) begin
            resolved = 1'b1;
            oc       = rqt_pkg::OC_FAILURE;
          end
          if (resolved) begin
            push_done(owner_id[s], owner_op[s], oc, 1'b1);
            live[s] = 1'b0;
          end
        end
      end
      rqt_pkg::REQ_TICK: begin
        now_q = now_q + 32'd1;
        for (int i = 0; i < rqt_pkg::SLOTS; i++) begin
          if (n < rqt_pkg::MAX_OUT && live[i] &&
              (now_q - opened_at[i]) > {16'd0, timeout_q}) begin
            if (prev >= 0)
              push_done(owner_id[prev], owner_op[prev], rqt_pkg::OC_TIMEOUT, 1'b0);
            prev    = i;
            live[i] = 1'b0;
            n++;
          end
        end
        if (prev >= 0) push_done(owner_id[prev], owner_op[prev], rqt_pkg::OC_TIMEOUT, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_done();
    done_t want;
    if (done_q.size() == 0) begin
      if (errors_o < 10)
        $display("%0t: unexpected transaction id=%h op=%0d oc=%0d last=%0b", $realtime,
                 out_done_id_o, out_done_op_o, out_outcome_o, out_last_o);
      errors_o++;
    end else begin
      want = done_q.pop_front();
      if (want.id !== out_done_id_o || want.op !== out_done_op_o ||
          want.oc !== out_outcome_o || want.last !== out_last_o) begin
        if (errors_o < 10)
          $display("%0t: exp id=%h op=%0d oc=%0d last=%0b, got id=%h op=%0d oc=%0d last=%0b",
                   $realtime, want.id, want.op, want.oc, want.last,
                   out_done_id_o, out_done_op_o, out_outcome_o, out_last_o);
        errors_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q.delete();
      for (int i = 0; i < rqt_pkg::SLOTS; i++) live[i] = 1'b0;
      now_q     = '0;
      timeout_q = rqt_pkg::TIMEOUT_RESET;
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_done();
      if (cfg_we_i) timeout_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_o)
        track_request(rqt_pkg::req_type_e'(in_req_type_i), in_trans_id_i, in_op_kind_i,
                      in_reply_ok_i);
      pending_o = done_q.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [rqt_pkg::TIMEOUT_W-1:0] cfg_wdata_i = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    in_req_type_i = '0;
  logic [rqt_pkg::ID_W-1:0]      in_trans_id_i = '0;
  logic [rqt_pkg::OP_W-1:0]      in_op_kind_i  = '0;
  logic                          in_reply_ok_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [rqt_pkg::ID_W-1:0]      out_done_id_o;
  logic [rqt_pkg::OP_W-1:0]      out_done_op_o;
  logic [1:0]                    out_outcome_o;
  logic                          out_last_o;

  int unsigned errors;
  int unsigned pending;
  int          tx_idle_pct = 35;
  int          rx_idle_pct = 76;
  logic        hold_start  = 1'b0;
  logic        hold_taken  = 1'b0;
  int          hold_cnt    = 0;
  logic [rqt_pkg::ID_W-1:0] recent_ids[$];

  replica_quorum_tracker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_req_type_i (in_req_type_i),
    .in_trans_id_i (in_trans_id_i),
    .in_op_kind_i  (in_op_kind_i),
    .in_reply_ok_i (in_reply_ok_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_done_id_o (out_done_id_o),
    .out_done_op_o (out_done_op_o),
    .out_outcome_o (out_outcome_o),
    .out_last_o    (out_last_o)
  );

  rqt_outcome_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_req_type_i (in_req_type_i),
    .in_trans_id_i (in_trans_id_i),
    .in_op_kind_i  (in_op_kind_i),
    .in_reply_ok_i (in_reply_ok_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_done_id_o (out_done_id_o),
    .out_done_op_o (out_done_op_o),
    .out_outcome_o (out_outcome_o),
    .out_last_o    (out_last_o),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stalls, with one long hold-off counted here
  always @(negedge clk_i) begin
    if (hold_cnt != 0) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt - 1;
    end else if (hold_start && !hold_taken) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= 200;
      hold_taken  <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_req(input rqt_pkg::req_type_e kind,
                          input logic [rqt_pkg::ID_W-1:0] id,
                          input logic [rqt_pkg::OP_W-1:0] op, input logic ok);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_req_type_i <= kind;
    in_trans_id_i <= id;
    in_op_kind_i  <= op;
    in_reply_ok_i <= ok;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [rqt_pkg::TIMEOUT_W-1:0] ticks);
    drain_all();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_traffic(input int count);
    int                       sent;
    int                       pick;
    logic [rqt_pkg::ID_W-1:0] id;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30 || recent_ids.size() == 0) begin
        id = rqt_pkg::ID_W'($urandom_range(0, 65535));
        send_req(rqt_pkg::REQ_OPEN, id, rqt_pkg::OP_W'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)));
        recent_ids.push_back(id);
        if (recent_ids.size() > 6) void'(recent_ids.pop_front());
        sent++;
      end else if (pick < 76) begin
        id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        send_req(rqt_pkg::REQ_REPLY, id, rqt_pkg::OP_W'($urandom_range(0, 3)),
                 $urandom_range(0, 99) < 60);
        sent++;
      end else if (pick < 90) begin
        send_req(rqt_pkg::REQ_TICK, rqt_pkg::ID_W'($urandom_range(0, 65535)),
                 rqt_pkg::OP_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < 95) begin
        send_req(rqt_pkg::REQ_REPLY, rqt_pkg::ID_W'($urandom_range(0, 65535)),
                 rqt_pkg::OP_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        send_req(rqt_pkg::REQ_NONE, rqt_pkg::ID_W'($urandom_range(0, 65535)),
                 rqt_pkg::OP_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // timeout at its reset value
    send_req(rqt_pkg::REQ_OPEN,  16'h0000, 2'd0, 1'b0);
    send_req(rqt_pkg::REQ_OPEN,  16'h0010, 2'd1, 1'b1);
    send_req(rqt_pkg::REQ_REPLY, 16'h0010, 2'd2, 1'b1);
    send_req(rqt_pkg::REQ_REPLY, 16'h0005, 2'd3, 1'b1);
    send_req(rqt_pkg::REQ_REPLY, 16'h0000, 2'd0, 1'b1);
    send_req(rqt_pkg::REQ_REPLY, 16'h0000, 2'd3, 1'b1);
    send_req(rqt_pkg::REQ_OPEN,  16'hFFFF, 2'd3, 1'b1);
    send_req(rqt_pkg::REQ_REPLY, 16'hFFFF, 2'd1, 1'b0);
    send_req(rqt_pkg::REQ_REPLY, 16'hFFFF, 2'd2, 1'b0);
    send_req(rqt_pkg::REQ_OPEN,  16'h1231, 2'd2, 1'b0);
    send_req(rqt_pkg::REQ_REPLY, 16'h1231, 2'd0, 1'b1);
    send_req(rqt_pkg::REQ_REPLY, 16'h1231, 2'd0, 1'b0);
    send_req(rqt_pkg::REQ_REPLY, 16'h1231, 2'd0, 1'b0);
    send_req(rqt_pkg::REQ_NONE,  16'hA5C3, 2'd3, 1'b1);
    send_req(rqt_pkg::REQ_TICK,  16'h5A3C, 2'd2, 1'b1);
    random_traffic(15);

    // zero timeout: every entry expires on the next tick, full table at once
    write_timeout(16'd0);
    send_req(rqt_pkg::REQ_TICK, 16'h0000, 2'd0, 1'b0);
    for (int i = 0; i < rqt_pkg::SLOTS; i++)
      send_req(rqt_pkg::REQ_OPEN, {12'($urandom_range(0, 4095)), 4'(i)}, 2'(i), 1'b0);
    send_req(rqt_pkg::REQ_TICK, 16'hFFFF, 2'd3, 1'b1);
    random_traffic(8);

    write_timeout(16'hFFFF);
    tx_idle_pct = 76;
    rx_idle_pct = 35;
    random_traffic(20);

    write_timeout(rqt_pkg::TIMEOUT_W'($urandom_range(1, 6)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_start <= 1'b1;
    random_traffic(15);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    random_traffic(15);

    drain_all();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
